FILE: rtl/rmth_pkg.sv
`default_nettype none
package rmth_pkg;

  // Default number of entries in each of the two heaps.
  localparam int HEAP_DEPTH_DEF = 512;

  // Field widths fixed by the interface.
  localparam int SAMPLE_W = 32;
  localparam int MED_W    = 33;
  localparam int CNT_W    = 11;

  // Datapath step codes issued by the controller.
  localparam logic [3:0] ST_NOP       = 4'd0;
  localparam logic [3:0] ST_LATCH     = 4'd1;
  localparam logic [3:0] ST_INS_INIT  = 4'd2;
  localparam logic [3:0] ST_INS_PAR   = 4'd3;
  localparam logic [3:0] ST_INS_CMP   = 4'd4;
  localparam logic [3:0] ST_TK_RD0    = 4'd5;
  localparam logic [3:0] ST_TK_RDLAST = 4'd6;
  localparam logic [3:0] ST_TK_LAST   = 4'd7;
  localparam logic [3:0] ST_TK_CHILD  = 4'd8;
  localparam logic [3:0] ST_TK_LEFT   = 4'd9;
  localparam logic [3:0] ST_TK_CMP    = 4'd10;
  localparam logic [3:0] ST_MED_RD    = 4'd11;
  localparam logic [3:0] ST_MED_SUM   = 4'd12;
  localparam logic [3:0] ST_OUT       = 4'd13;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic [3:0] step;
    logic       other;    // work on the heap opposite the one the sample joins
    logic       use_top;  // insert the element taken from the other heap
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic refused;
    logic take;
    logic ins_root;
    logic ins_move;
    logic tk_leaf;
    logic tk_move;
    logic out_free;
  } stat_t;

  // True when a belongs above b in the heap (max-heap or min-heap).
  function automatic logic goes_first(input logic signed [SAMPLE_W-1:0] a,
                                      input logic signed [SAMPLE_W-1:0] b,
                                      input logic is_max);
    goes_first = is_max ? (a > b) : (a < b);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/rmth_datapath.sv
`default_nettype none
module rmth_datapath #(
  parameter int HEAP_DEPTH = rmth_pkg::HEAP_DEPTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic signed [rmth_pkg::SAMPLE_W-1:0] sample,
  input  wire rmth_pkg::cmd_t                       cmd,
  output rmth_pkg::stat_t                           stat,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic        [rmth_pkg::MED_W-1:0]         out_median,
  output logic        [rmth_pkg::CNT_W-1:0]         out_count,
  output logic                                      out_refused
);

  localparam int IW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int SW = IW + 1;
  localparam int XW = IW + 2;

  logic signed [rmth_pkg::SAMPLE_W-1:0] mem_l [HEAP_DEPTH];
  logic signed [rmth_pkg::SAMPLE_W-1:0] mem_u [HEAP_DEPTH];
  logic signed [rmth_pkg::SAMPLE_W-1:0] rd_l, rd_u;

  logic signed [rmth_pkg::SAMPLE_W-1:0] s_reg, top_reg, val_reg, l_reg;
  logic        [SW-1:0]                 lsize, usize, cnt;
  logic signed [rmth_pkg::MED_W-1:0]    median_reg;
  logic                                 bal_q, take_q, refused_q, h_q, have_r;
  logic        [IW-1:0]                 idx;

  logic                                 heap, is_max;
  logic signed [rmth_pkg::SAMPLE_W-1:0] rd, ch_val, wd;
  logic        [SW-1:0]                 hsize;
  logic        [IW-1:0]                 par, ch_idx, ra, wa;
  logic        [XW-1:0]                 lch, rch, cnt_x, tot;
  logic                                 leaf, r_in, use_r, ins_move, tk_move, we;
  logic                                 above, full, out_free;

  // Heap selection and tree arithmetic.
  assign heap     = h_q ^ cmd.other;
  assign is_max   = !heap;
  assign rd       = heap ? rd_u : rd_l;
  assign hsize    = heap ? usize : lsize;
  assign par      = (idx - IW'(1)) >> 1;
  assign lch      = XW'({idx, 1'b0}) + XW'(1);
  assign rch      = lch + XW'(1);
  assign cnt_x    = XW'(cnt);
  assign leaf     = lch >= cnt_x;
  assign r_in     = rch < cnt_x;
  assign use_r    = have_r && rmth_pkg::goes_first(rd, l_reg, is_max);
  assign ch_val   = use_r ? rd : l_reg;
  assign ch_idx   = use_r ? rch[IW-1:0] : lch[IW-1:0];
  assign ins_move = rmth_pkg::goes_first(val_reg, rd, is_max);
  assign tk_move  = rmth_pkg::goes_first(ch_val, val_reg, is_max);

  // Decision on the arriving sample.
  assign tot   = XW'(lsize) + XW'(usize);
  assign full  = tot >= XW'(2 * HEAP_DEPTH);
  assign above = $signed({sample[rmth_pkg::SAMPLE_W-1], sample, 1'b0}) >
                 $signed({median_reg[rmth_pkg::MED_W-1], median_reg});
  assign out_free = !out_valid || out_ready;

  // Memory addressing for each step.
  always_comb begin
    ra = '0;
    we = 1'b0;
    wa = idx;
    wd = val_reg;
    unique case (cmd.step)
      rmth_pkg::ST_INS_PAR: begin
        ra = par;
        we = (idx == '0);
      end
      rmth_pkg::ST_INS_CMP: begin
        ra = par;
        we = 1'b1;
        if (ins_move) begin
          wd = rd;
        end
      end
      rmth_pkg::ST_TK_RDLAST: ra = cnt[IW-1:0];
      rmth_pkg::ST_TK_CHILD: begin
        ra = lch[IW-1:0];
        we = leaf;
      end
      rmth_pkg::ST_TK_LEFT: ra = rch[IW-1:0];
      rmth_pkg::ST_TK_CMP: begin
        we = 1'b1;
        if (tk_move) begin
          wd = ch_val;
        end
      end
      default: ra = '0;
    endcase
  end

  // Lower heap storage.
  always_ff @(posedge clk) begin
    if (we && !heap) begin
      mem_l[wa] <= wd;
    end
    rd_l <= mem_l[ra];
  end

  // Upper heap storage.
  always_ff @(posedge clk) begin
    if (we && heap) begin
      mem_u[wa] <= wd;
    end
    rd_u <= mem_u[ra];
  end

  // Working registers updated by each step.
  always_ff @(posedge clk) begin
    unique case (cmd.step)
      rmth_pkg::ST_LATCH: begin
        s_reg     <= sample;
        refused_q <= full;
        bal_q     <= (lsize == usize);
        h_q       <= above;
        take_q    <= ((lsize > usize) && !above) || ((usize > lsize) && above);
      end
      rmth_pkg::ST_INS_INIT: begin
        idx     <= hsize[IW-1:0];
        val_reg <= cmd.use_top ? top_reg : s_reg;
      end
      rmth_pkg::ST_INS_CMP: begin
        if (ins_move) begin
          idx <= par;
        end
      end
      rmth_pkg::ST_TK_RD0:    cnt <= hsize - SW'(1);
      rmth_pkg::ST_TK_RDLAST: top_reg <= rd;
      rmth_pkg::ST_TK_LAST: begin
        val_reg <= rd;
        idx     <= '0;
      end
      rmth_pkg::ST_TK_LEFT: begin
        l_reg  <= rd;
        have_r <= r_in;
      end
      rmth_pkg::ST_TK_CMP: begin
        if (tk_move) begin
          idx <= ch_idx;
        end
      end
      default: begin
      end
    endcase
  end

  // Heap sizes, running median and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      lsize      <= '0;
      usize      <= '0;
      median_reg <= '0;
      out_valid  <= 1'b0;
    end else begin
      case (cmd.step)
        rmth_pkg::ST_INS_INIT: begin
          if (heap) begin
            usize <= usize + SW'(1);
          end else begin
            lsize <= lsize + SW'(1);
          end
        end
        rmth_pkg::ST_TK_RD0: begin
          if (heap) begin
            usize <= usize - SW'(1);
          end else begin
            lsize <= lsize - SW'(1);
          end
        end
        rmth_pkg::ST_MED_SUM: begin
          if (bal_q) begin
            median_reg <= h_q ? {rd_u, 1'b0} : {rd_l, 1'b0};
          end else begin
            median_reg <= {rd_l[rmth_pkg::SAMPLE_W-1], rd_l} +
                          {rd_u[rmth_pkg::SAMPLE_W-1], rd_u};
          end
        end
        default: begin
        end
      endcase
      // A new result is loaded when the register is free; otherwise it drains.
      if (cmd.step == rmth_pkg::ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd.step == rmth_pkg::ST_OUT && out_free) begin
      out_median  <= median_reg;
      out_count   <= rmth_pkg::CNT_W'(tot);
      out_refused <= refused_q;
    end
  end

  assign stat.refused  = refused_q;
  assign stat.take     = take_q;
  assign stat.ins_root = (idx == '0);
  assign stat.ins_move = ins_move;
  assign stat.tk_leaf  = leaf;
  assign stat.tk_move  = tk_move;
  assign stat.out_free = out_free;

endmodule
`default_nettype wire

FILE: rtl/rmth_ctrl.sv
`default_nettype none
module rmth_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output rmth_pkg::cmd_t       cmd,
  input  wire rmth_pkg::stat_t stat
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECIDE    = 4'd1;
  localparam logic [3:0] S_INS_INIT  = 4'd2;
  localparam logic [3:0] S_INS_PAR   = 4'd3;
  localparam logic [3:0] S_INS_CMP   = 4'd4;
  localparam logic [3:0] S_TK_RD0    = 4'd5;
  localparam logic [3:0] S_TK_RDLAST = 4'd6;
  localparam logic [3:0] S_TK_LAST   = 4'd7;
  localparam logic [3:0] S_TK_CHILD  = 4'd8;
  localparam logic [3:0] S_TK_LEFT   = 4'd9;
  localparam logic [3:0] S_TK_CMP    = 4'd10;
  localparam logic [3:0] S_MED_RD    = 4'd11;
  localparam logic [3:0] S_MED_SUM   = 4'd12;
  localparam logic [3:0] S_OUT       = 4'd13;

  // Which heap operation of the current item is running.
  localparam logic [1:0] PH_TAKE    = 2'd0;
  localparam logic [1:0] PH_INS_TOP = 2'd1;
  localparam logic [1:0] PH_INS_S   = 2'd2;

  logic [3:0] state, state_next;
  logic [1:0] phase, phase_next;
  logic       ins_done;

  assign in_ready = (state == S_IDLE);

  // Step command for the datapath.
  always_comb begin
    cmd.use_top = (phase == PH_INS_TOP);
    cmd.other   = (phase == PH_INS_TOP);
    unique case (state)
      S_IDLE:      cmd.step = in_valid ? rmth_pkg::ST_LATCH : rmth_pkg::ST_NOP;
      S_INS_INIT:  cmd.step = rmth_pkg::ST_INS_INIT;
      S_INS_PAR:   cmd.step = rmth_pkg::ST_INS_PAR;
      S_INS_CMP:   cmd.step = rmth_pkg::ST_INS_CMP;
      S_TK_RD0:    cmd.step = rmth_pkg::ST_TK_RD0;
      S_TK_RDLAST: cmd.step = rmth_pkg::ST_TK_RDLAST;
      S_TK_LAST:   cmd.step = rmth_pkg::ST_TK_LAST;
      S_TK_CHILD:  cmd.step = rmth_pkg::ST_TK_CHILD;
      S_TK_LEFT:   cmd.step = rmth_pkg::ST_TK_LEFT;
      S_TK_CMP:    cmd.step = rmth_pkg::ST_TK_CMP;
      S_MED_RD:    cmd.step = rmth_pkg::ST_MED_RD;
      S_MED_SUM:   cmd.step = rmth_pkg::ST_MED_SUM;
      S_OUT:       cmd.step = rmth_pkg::ST_OUT;
      default:     cmd.step = rmth_pkg::ST_NOP;
    endcase
  end

  // An insertion ends at the root or when the element does not rank above its parent.
  always_comb begin
    ins_done = ((state == S_INS_PAR) && stat.ins_root) ||
               ((state == S_INS_CMP) && !stat.ins_move);
  end

  // Sequencing of the heap operations for one transaction.
  always_comb begin
    state_next = state;
    phase_next = phase;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.refused) begin
          state_next = S_OUT;
        end else if (stat.take) begin
          phase_next = PH_TAKE;
          state_next = S_TK_RD0;
        end else begin
          phase_next = PH_INS_S;
          state_next = S_INS_INIT;
        end
      end
      S_INS_INIT: state_next = S_INS_PAR;
      S_INS_PAR, S_INS_CMP: begin
        if (ins_done) begin
          if (phase == PH_INS_TOP) begin
            phase_next = PH_INS_S;
            state_next = S_INS_INIT;
          end else begin
            state_next = S_MED_RD;
          end
        end else if (state == S_INS_PAR) begin
          state_next = S_INS_CMP;
        end else begin
          // The element moved up one level; read its new parent.
          state_next = S_INS_PAR;
        end
      end
      S_TK_RD0:    state_next = S_TK_RDLAST;
      S_TK_RDLAST: state_next = S_TK_LAST;
      S_TK_LAST:   state_next = S_TK_CHILD;
      S_TK_CHILD: begin
        if (stat.tk_leaf) begin
          phase_next = PH_INS_TOP;
          state_next = S_INS_INIT;
        end else begin
          state_next = S_TK_LEFT;
        end
      end
      S_TK_LEFT: state_next = S_TK_CMP;
      S_TK_CMP: begin
        if (stat.tk_move) begin
          state_next = S_TK_CHILD;
        end else begin
          phase_next = PH_INS_TOP;
          state_next = S_INS_INIT;
        end
      end
      S_MED_RD:  state_next = S_MED_SUM;
      S_MED_SUM: state_next = S_OUT;
      S_OUT: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_INS_S;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/running_median_two_heaps.sv
`default_nettype none
// Running median over a stream of signed 32-bit samples, kept in a max-heap
// (lower half) and a min-heap (upper half) of HEAP_DEPTH entries each. One
// transaction is taken at a time; each gives one result with twice the
// median, the number of samples held and a refused flag, set when both heaps
// are full and the sample was dropped. The time from one accepted
// transaction to the next is set by the heap sifts and by any stall on the
// result output: each tree level takes a parent read and a compare step when
// inserting, and a left-child read, a right-child read and a compare step when
// removing a top, since every level needs a registered read of the single
// read port of a heap memory before its compare and write. A refused sample
// skips the heaps. The heap memories are not cleared at reset and need no
// clearing pass; only written entries are ever used.
module running_median_two_heaps #(
  parameter int HEAP_DEPTH = rmth_pkg::HEAP_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] sample
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // [32:0] median_doubled, [43:33] held_count
  output logic             m_tuser    // [0] refused
);

  rmth_pkg::cmd_t                    cmd;
  rmth_pkg::stat_t                   stat;
  logic [rmth_pkg::MED_W-1:0]        median;
  logic [rmth_pkg::CNT_W-1:0]        count;

  rmth_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  rmth_datapath #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .sample      (s_tdata),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_median  (median),
    .out_count   (count),
    .out_refused (m_tuser)
  );

  assign m_tdata = {4'b0000, count, median};

endmodule
`default_nettype wire

FILE: rtl/rmth_checker.sv
`default_nettype none
module rmth_checker #(
  parameter int HEAP_DEPTH = rmth_pkg::HEAP_DEPTH_DEF
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [31:0] s_tdata,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata,
  input wire logic        m_tuser
);

  localparam logic [rmth_pkg::CNT_W-1:0] FULL_CNT = rmth_pkg::CNT_W'(2 * HEAP_DEPTH);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Only one sample is in work at a time.
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while busy");

  // A refused sample is reported only with a full store.
  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[43:33] == FULL_CNT)
    else $error("refused without full store");

  // An accepted sample leaves at least one sample held.
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[43:33] != '0)
    else $error("empty count after accepted sample");

  // The padding of the result stays zero.
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[47:44] == 4'b0000)
    else $error("result padding not zero");

endmodule

bind running_median_two_heaps rmth_checker #(.HEAP_DEPTH(HEAP_DEPTH)) u_rmth_checker (.*);
`default_nettype wire
